// ----- sv/es2c_pkg.sv -----
`timescale 1ns / 1ps
// es2c_pkg: stage indices, field widths, reciprocal constants, month table and DST rule
// for the epoch-seconds to calendar converter. No dependencies.
package es2c_pkg;

  // Pipeline stage indices, input register first, result register last
  localparam int unsigned ST_IN     = 0;
  localparam int unsigned ST_DAY    = 1;
  localparam int unsigned ST_ERA    = 2;
  localparam int unsigned ST_DIV    = 3;
  localparam int unsigned ST_SUB    = 4;
  localparam int unsigned ST_QUOT   = 5;
  localparam int unsigned ST_FOLD   = 6;
  localparam int unsigned ST_ALIGN  = 7;
  localparam int unsigned ST_OUT    = 8;
  localparam int unsigned NUM_STAGES = 9;

  typedef logic [NUM_STAGES-1:0] adv_t;

  // Field widths
  localparam int unsigned SECS_W   = 34;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned DAYS_W   = 18;
  localparam int unsigned SOD_W    = 17;  // seconds of the day
  localparam int unsigned SOH_W    = 12;  // seconds of the hour
  localparam int unsigned DOE_W    = 18;  // day of the 400-year era
  localparam int unsigned ERA_W    = 2;
  localparam int unsigned YOE_W    = 9;   // March-based year of the era
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned YEAR_W   = 10;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MDAY_W   = 5;
  localparam int unsigned MON_W    = 4;
  localparam int unsigned WDAY_W   = 3;

  // Seconds to days: 86400 = 675 * 2^7, quotient by reciprocal of 675
  localparam int unsigned DAY_LO_W   = 7;
  localparam int unsigned DAY_DIV    = 675;
  localparam logic [27:0] DAY_RECIP  = 28'd203613265;
  localparam int unsigned DAY_SHIFT  = 37;

  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam logic [17:0] HOUR_RECIP = 18'd149131;
  localparam int unsigned HOUR_SHIFT = 29;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam logic [12:0] MIN_RECIP  = 13'd4370;
  localparam int unsigned MIN_SHIFT  = 18;

  // 1970-01-01 was a Thursday
  localparam int unsigned EPOCH_WEEKDAY = 4;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam logic [18:0] WEEK_RECIP = 19'd299594;
  localparam int unsigned WEEK_SHIFT = 21;

  // Civil date: days counted from 1600-03-01, split into 400-year eras
  localparam int unsigned DAY_OFFSET = 135080;
  localparam int unsigned ERA_DAYS   = 146097;
  localparam int unsigned CENT_DAYS  = 36524;
  localparam int unsigned ERA_LAST   = 146096;
  localparam logic [18:0] QUAD_RECIP = 19'd367720;  // 1 / 1460
  localparam int unsigned QUAD_SHIFT = 29;
  localparam logic [18:0] YEAR_RECIP = 19'd367720;  // 1 / 365
  localparam int unsigned YEAR_SHIFT = 27;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned YEARS_PER_ERA = 400;
  localparam int unsigned BASE_YEAR  = 1600;
  localparam int unsigned YEAR_BIAS  = 1900;
  localparam int unsigned MAR_YEAR_DAYS = 306;  // March through December
  localparam int unsigned JAN_FEB_DAYS  = 59;

  localparam logic [MON_W-1:0] MONTH_DEC = 4'd11;
  localparam logic [MON_W-1:0] MONTH_MAR = 4'd2;
  localparam logic [MON_W-1:0] MONTH_NOV = 4'd10;
  localparam logic signed [6:0] MARCH_SUNDAY_MIN = 7'sd8;

  localparam logic [DOY_W-1:0] MONTH_START [2][13] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
      9'd304, 9'd334, 9'd365},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274,
      9'd305, 9'd335, 9'd366}
  };

  // US rule: second Sunday of March through first Sunday of November
  function automatic logic dst_rule(logic [MON_W-1:0] mon, logic [MDAY_W-1:0] mday,
                                    logic [WDAY_W-1:0] wday);
    logic signed [6:0] prev_sun;
    logic flag;
    prev_sun = signed'({2'b00, mday}) - signed'({4'b0000, wday});
    if (mon < MONTH_MAR || mon > MONTH_NOV) begin
      flag = 1'b0;
    end else if (mon > MONTH_MAR && mon < MONTH_NOV) begin
      flag = 1'b1;
    end else if (mon == MONTH_MAR) begin
      flag = (prev_sun >= MARCH_SUNDAY_MIN);
    end else begin
      flag = (prev_sun <= 7'sd0);
    end
    return flag;
  endfunction

endpackage

// ----- sv/es2c_tod.sv -----
`timescale 1ns / 1ps
// es2c_tod: hour, minute, second and weekday from seconds of day and day count,
// stages three to seven of the converter pipeline. Depends on es2c_pkg.
module es2c_tod (
  input  logic                         clk_i,
  input  es2c_pkg::adv_t               adv_i,
  input  logic [es2c_pkg::SOD_W-1:0]   sod_i,
  input  logic [es2c_pkg::DAYS_W-1:0]  days_i,
  output logic [es2c_pkg::HOUR_W-1:0]  hour_o,
  output logic [es2c_pkg::SEC_W-1:0]   minute_o,
  output logic [es2c_pkg::SEC_W-1:0]   second_o,
  output logic [es2c_pkg::WDAY_W-1:0]  weekday_o
);
  import es2c_pkg::*;

  logic [SOD_W-1:0]  sod3_q;
  logic [HOUR_W-1:0] hour3_q, hour4_q, hour5_q, hour6_q;
  logic [DAYS_W-1:0] wx3_q;
  logic [14:0]       wq3_q;
  logic [SOH_W-1:0]  soh4_q, soh5_q;
  logic [WDAY_W-1:0] wday4_q, wday5_q, wday6_q;
  logic [SEC_W-1:0]  min5_q, min6_q, sec6_q;

  logic [34:0]       hour_prod;
  logic [DAYS_W-1:0] wx_d;
  logic [36:0]       week_prod;
  logic [SOD_W-1:0]  soh_full;
  logic [DAYS_W-1:0] wday_full;
  logic [24:0]       min_prod;
  logic [SOH_W-1:0]  sec_full;

  always_comb begin
    hour_prod = 35'(sod_i) * 35'(HOUR_RECIP);
    wx_d      = days_i + DAYS_W'(EPOCH_WEEKDAY);
    week_prod = 37'(wx_d) * 37'(WEEK_RECIP);
    soh_full  = sod3_q - SOD_W'(SOD_W'(hour3_q) * SOD_W'(SECS_PER_HOUR));
    wday_full = wx3_q - DAYS_W'(DAYS_W'(wq3_q) * DAYS_W'(DAYS_PER_WEEK));
    min_prod  = 25'(soh4_q) * 25'(MIN_RECIP);
    sec_full  = soh5_q - SOH_W'(SOH_W'(min5_q) * SOH_W'(SECS_PER_MIN));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[ST_DIV]) begin
      sod3_q  <= sod_i;
      hour3_q <= hour_prod[HOUR_SHIFT +: HOUR_W];
      wx3_q   <= wx_d;
      wq3_q   <= week_prod[WEEK_SHIFT +: 15];
    end
    if (adv_i[ST_SUB]) begin
      hour4_q <= hour3_q;
      soh4_q  <= soh_full[SOH_W-1:0];
      wday4_q <= wday_full[WDAY_W-1:0];
    end
    if (adv_i[ST_QUOT]) begin
      hour5_q <= hour4_q;
      soh5_q  <= soh4_q;
      min5_q  <= min_prod[MIN_SHIFT +: SEC_W];
      wday5_q <= wday4_q;
    end
    if (adv_i[ST_FOLD]) begin
      hour6_q <= hour5_q;
      min6_q  <= min5_q;
      sec6_q  <= sec_full[SEC_W-1:0];
      wday6_q <= wday5_q;
    end
    if (adv_i[ST_ALIGN]) begin
      hour_o    <= hour6_q;
      minute_o  <= min6_q;
      second_o  <= sec6_q;
      weekday_o <= wday6_q;
    end
  end

endmodule

// ----- sv/es2c_date.sv -----
`timescale 1ns / 1ps
// es2c_date: calendar year, day of year and leap flag from the day of a 400-year era,
// stages three to seven of the converter pipeline. Depends on es2c_pkg.
module es2c_date (
  input  logic                         clk_i,
  input  es2c_pkg::adv_t               adv_i,
  input  logic [es2c_pkg::DOE_W-1:0]   doe_i,
  input  logic [es2c_pkg::ERA_W-1:0]   era_i,
  output logic [es2c_pkg::DOY_W-1:0]   yday_o,
  output logic [es2c_pkg::YEAR_W-1:0]  year_o,
  output logic                         leap_o
);
  import es2c_pkg::*;

  logic [DOE_W-1:0]  doe3_q, doe4_q, doe5_q;
  logic [ERA_W-1:0]  era3_q, era4_q, era5_q;
  logic [6:0]        quad3_q;
  logic [2:0]        cent3_q;
  logic              last3_q;
  logic [DOE_W-1:0]  num4_q;
  logic [YOE_W-1:0]  yoe5_q;
  logic [DOY_W-1:0]  doy6_q;
  logic              leap6_q;
  logic [YEAR_W-1:0] ybase6_q;

  logic [36:0]       quad_prod;
  logic [2:0]        cent_d;
  logic [DOE_W-1:0]  num_d;
  logic [36:0]       year_prod;
  logic [1:0]        yoe_cent;
  logic [16:0]       year_days;
  logic [DOE_W-1:0]  doy_full;
  logic [10:0]       ybase_full;
  logic              leap_d;
  logic              jan_feb;

  always_comb begin
    quad_prod = 37'(doe_i) * 37'(QUAD_RECIP);
    if (doe_i >= DOE_W'(4 * CENT_DAYS)) begin
      cent_d = 3'd4;
    end else if (doe_i >= DOE_W'(3 * CENT_DAYS)) begin
      cent_d = 3'd3;
    end else if (doe_i >= DOE_W'(2 * CENT_DAYS)) begin
      cent_d = 3'd2;
    end else if (doe_i >= DOE_W'(CENT_DAYS)) begin
      cent_d = 3'd1;
    end else begin
      cent_d = 3'd0;
    end

    // drop the leap days so that a plain divide by 365 gives the year
    num_d = doe3_q - DOE_W'(quad3_q) + DOE_W'(cent3_q) - DOE_W'(last3_q);
    year_prod = 37'(num4_q) * 37'(YEAR_RECIP);

    if (yoe5_q >= YOE_W'(300)) begin
      yoe_cent = 2'd3;
    end else if (yoe5_q >= YOE_W'(200)) begin
      yoe_cent = 2'd2;
    end else if (yoe5_q >= YOE_W'(100)) begin
      yoe_cent = 2'd1;
    end else begin
      yoe_cent = 2'd0;
    end
    year_days = 17'(17'(yoe5_q) * 17'(DAYS_PER_YEAR)) + 17'(yoe5_q >> 2) - 17'(yoe_cent);
    doy_full  = doe5_q - DOE_W'(year_days);
    // era years are aligned to multiples of 400, so the leap test sees only yoe
    leap_d = (yoe5_q[1:0] == 2'b00) && (yoe5_q != YOE_W'(100)) &&
             (yoe5_q != YOE_W'(200)) && (yoe5_q != YOE_W'(300));
    ybase_full = 11'(11'(era5_q) * 11'(YEARS_PER_ERA)) + 11'(yoe5_q) -
                 11'(YEAR_BIAS - BASE_YEAR);

    jan_feb = (doy6_q >= DOY_W'(MAR_YEAR_DAYS));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[ST_DIV]) begin
      doe3_q  <= doe_i;
      era3_q  <= era_i;
      quad3_q <= quad_prod[QUAD_SHIFT +: 7];
      cent3_q <= cent_d;
      last3_q <= (doe_i == DOE_W'(ERA_LAST));
    end
    if (adv_i[ST_SUB]) begin
      doe4_q <= doe3_q;
      era4_q <= era3_q;
      num4_q <= num_d;
    end
    if (adv_i[ST_QUOT]) begin
      doe5_q <= doe4_q;
      era5_q <= era4_q;
      yoe5_q <= year_prod[YEAR_SHIFT +: YOE_W];
    end
    if (adv_i[ST_FOLD]) begin
      doy6_q   <= doy_full[DOY_W-1:0];
      leap6_q  <= leap_d;
      ybase6_q <= ybase_full[YEAR_W-1:0];
    end
    if (adv_i[ST_ALIGN]) begin
      // January and February belong to the next calendar year
      if (jan_feb) begin
        yday_o <= doy6_q - DOY_W'(MAR_YEAR_DAYS);
      end else begin
        yday_o <= doy6_q + DOY_W'(JAN_FEB_DAYS) + DOY_W'(leap6_q);
      end
      year_o <= ybase6_q + YEAR_W'(jan_feb);
      // in January and February only Feb 29 depends on the leap month table
      leap_o <= leap6_q | jan_feb;
    end
  end

endmodule

// ----- sv/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
// epoch_seconds_to_calendar: UTC seconds since 1970 to broken-down calendar time.
// Depends on es2c_pkg, es2c_tod and es2c_date.
//
//   channel  | direction | tdata fields (lsb first)
//   s_axis   | in        | epoch_seconds[33:0]
//   m_axis   | out       | second, minute, hour, day_of_month, month, year_since_1900,
//            |           | weekday, day_of_year, dst_flag
//
// Nine register stages, input register to result register. One request is taken every
// cycle unless a stall at m_axis holds every stage full.
// A stall at m_axis holds the full stages; empty stages ahead still fill, and
// s_axis_tready falls only when every stage holds a request. Reset clears the valid bits.
module epoch_seconds_to_calendar (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // epoch_seconds[33:0], zero fill above
  input  logic [es2c_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // second[5:0], minute[11:6], hour[16:12], day_of_month[21:17], month[25:22],
  // year_since_1900[35:26], weekday[38:36], day_of_year[47:39], dst_flag[48], zero fill
  output logic [es2c_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import es2c_pkg::*;

  adv_t                       adv;
  logic [NUM_STAGES-1:0]      vld_q, vld_d;

  logic [SECS_W-1:0]          t_q;
  logic [DAYS_W-1:0]          days1_q, days2_q;
  logic [SECS_W-DAY_LO_W-1:0] thi1_q;
  logic [DAY_LO_W-1:0]        tlo1_q;
  logic [SOD_W-1:0]           sod2_q;
  logic [DOE_W-1:0]           doe2_q;
  logic [ERA_W-1:0]           era2_q;

  logic [54:0]                day_prod;
  logic [27:0]                day_base;
  logic [27:0]                hi_rem;
  logic [18:0]                zday;
  logic [DOE_W-1:0]           doe_d;
  logic [ERA_W-1:0]           era_d;

  logic [HOUR_W-1:0]          hour7;
  logic [SEC_W-1:0]           min7, sec7;
  logic [WDAY_W-1:0]          wday7;
  logic [DOY_W-1:0]           yday7;
  logic [YEAR_W-1:0]          year7;
  logic                       leap7;

  logic [MON_W-1:0]           mon_d;
  logic [MDAY_W-1:0]          mday_d;
  logic [DOY_W-1:0]           mday_full;

  logic [SEC_W-1:0]           sec_q, min_q;
  logic [HOUR_W-1:0]          hour_q;
  logic [MDAY_W-1:0]          mday_q;
  logic [MON_W-1:0]           mon_q;
  logic [YEAR_W-1:0]          year_q;
  logic [WDAY_W-1:0]          wday_q;
  logic [DOY_W-1:0]           yday_q;
  logic                       dst_q;

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = adv[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[ST_IN];
  assign m_axis_tvalid = vld_q[ST_OUT];

  always_comb begin
    day_prod = 55'(t_q[SECS_W-1:DAY_LO_W]) * 55'(DAY_RECIP);
    day_base = 28'(days1_q) * 28'(DAY_DIV);
    hi_rem   = 28'(thi1_q) - day_base;
    zday     = 19'(days1_q) + 19'(DAY_OFFSET);
    if (zday >= 19'(2 * ERA_DAYS)) begin
      era_d = 2'd2;
      doe_d = DOE_W'(zday - 19'(2 * ERA_DAYS));
    end else if (zday >= 19'(ERA_DAYS)) begin
      era_d = 2'd1;
      doe_d = DOE_W'(zday - 19'(ERA_DAYS));
    end else begin
      era_d = 2'd0;
      doe_d = DOE_W'(zday);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_IN]) begin
      t_q <= s_axis_tdata[SECS_W-1:0];
    end
    if (adv[ST_DAY]) begin
      days1_q <= day_prod[DAY_SHIFT +: DAYS_W];
      thi1_q  <= t_q[SECS_W-1:DAY_LO_W];
      tlo1_q  <= t_q[DAY_LO_W-1:0];
    end
    if (adv[ST_ERA]) begin
      days2_q <= days1_q;
      sod2_q  <= {hi_rem[9:0], tlo1_q};
      doe2_q  <= doe_d;
      era2_q  <= era_d;
    end
  end

  es2c_tod u_tod (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .sod_i     (sod2_q),
    .days_i    (days2_q),
    .hour_o    (hour7),
    .minute_o  (min7),
    .second_o  (sec7),
    .weekday_o (wday7)
  );

  es2c_date u_date (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .doe_i  (doe2_q),
    .era_i  (era2_q),
    .yday_o (yday7),
    .year_o (year7),
    .leap_o (leap7)
  );

  // month is the last one whose first day is not after the day of year
  always_comb begin
    mon_d = MONTH_DEC;
    for (int i = 11; i >= 1; i--) begin
      if (MONTH_START[leap7][i] > yday7) begin
        mon_d = MON_W'(i - 1);
      end
    end
    mday_full = yday7 - MONTH_START[leap7][mon_d] + DOY_W'(1);
    mday_d    = mday_full[MDAY_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[ST_OUT]) begin
      sec_q  <= sec7;
      min_q  <= min7;
      hour_q <= hour7;
      mday_q <= mday_d;
      mon_q  <= mon_d;
      year_q <= year7;
      wday_q <= wday7;
      yday_q <= yday7;
      dst_q  <= dst_rule(mon_d, mday_d, wday7);
    end
  end

  assign m_axis_tdata = {7'd0, dst_q, yday_q, wday_q, year_q, mon_q, mday_q, hour_q,
                         min_q, sec_q};

endmodule

// ----- sv/es2c_checker.sv -----
`timescale 1ns / 1ps
// es2c_checker: port-level assertions for epoch_seconds_to_calendar, bound to the top level.
// Depends on es2c_pkg.
module es2c_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [es2c_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [es2c_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import es2c_pkg::*;

  // hold a stalled result
  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // back pressure reaches the input only when the pipeline is full and blocked
  a_ready_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without an output stall");

  // a taken result frees room for a new request in the same cycle
  a_drain_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input refused while output drains");

endmodule

bind epoch_seconds_to_calendar es2c_checker u_es2c_checker (.*);
